// ===== rtl/prjse3_pkg.sv =====
`default_nettype none
package prjse3_pkg;

    localparam int ROW_W          = 60;
    localparam int ENT_W          = 20;
    localparam int NENT           = 3;
    localparam int CRD_W          = 32;
    localparam int MD_W           = 17;
    localparam int IN_W           = 376;
    localparam int OUT_W          = 288;
    localparam int PRD_W          = CRD_W + ENT_W;
    localparam int AW             = PRD_W + 1;
    localparam int LO_W           = 26;
    localparam int HI_W           = AW - LO_W;
    localparam int PP_W           = HI_W + CRD_W;
    localparam int MUL_W          = AW + CRD_W;
    localparam int NUM_W          = MUL_W + 1;
    localparam int SQ_W           = 2 * CRD_W;
    localparam int QW             = 32;
    localparam int NLANE          = 6;
    localparam int NPNT           = 3;
    localparam int FST            = 8;
    localparam int COORD_FRAC_DEF = 16;
    localparam int ROT_FRAC_DEF   = 18;

    localparam logic [MD_W-1:0] MIN_DEPTH_RST = 17'd1;

    typedef struct packed {
        logic             last;
        logic [ROW_W-1:0] a_row;
        logic [ROW_W-1:0] b_row;
        logic [CRD_W-1:0] wx;
        logic [CRD_W-1:0] wy;
        logic [CRD_W-1:0] wz;
        logic [CRD_W-1:0] q;
        logic [CRD_W-1:0] cz;
    } t_row;

    typedef struct packed {
        logic last;
        logic bad;
    } t_side;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int f_ns(input int coord, input int rot);
        return (coord > rot) ? coord - rot : 0;
    endfunction

    function automatic int f_ds(input int coord, input int rot);
        return (rot > coord) ? rot - coord : 0;
    endfunction

    function automatic int f_dw(input int coord, input int rot);
        return SQ_W + f_ds(coord, rot);
    endfunction

    function automatic int f_nw(input int coord, input int rot);
        return f_max(NUM_W + f_ns(coord, rot) + 1, f_dw(coord, rot)) + 1;
    endfunction

    function automatic int f_ddw(input int coord, input int rot);
        return f_dw(coord, rot) + 1;
    endfunction

    function automatic int f_cw(input int coord, input int rot);
        return f_max(f_nw(coord, rot), f_ddw(coord, rot) + QW);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/prjse3_row_gen.sv =====
`default_nettype none
module prjse3_row_gen
    import prjse3_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_ce,
    input  wire logic            i_valid,
    input  wire logic [IN_W-1:0] i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output t_row                 o_row
);

    logic             r_have;
    logic             r_phase;
    logic [ROW_W-1:0] r_rot0;
    logic [ROW_W-1:0] r_rot1;
    logic [ROW_W-1:0] r_rot2;
    logic [CRD_W-1:0] r_wx;
    logic [CRD_W-1:0] r_wy;
    logic [CRD_W-1:0] r_wz;
    logic [CRD_W-1:0] r_cx;
    logic [CRD_W-1:0] r_cy;
    logic [CRD_W-1:0] r_cz;
    logic             w_acc;

    assign o_ready = !r_have || (r_phase && i_ce);
    assign w_acc   = i_valid && o_ready;
    assign o_valid = r_have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (i_ce && r_have) begin
                if (r_phase) begin
                    r_have  <= 1'b0;
                    r_phase <= 1'b0;
                end else begin
                    r_phase <= 1'b1;
                end
            end
            if (w_acc) begin
                r_have  <= 1'b1;
                r_phase <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rot0 <= i_data[0 +: ROW_W];
            r_rot1 <= i_data[ROW_W +: ROW_W];
            r_rot2 <= i_data[2*ROW_W +: ROW_W];
            r_wx   <= i_data[3*ROW_W +: CRD_W];
            r_wy   <= i_data[3*ROW_W + CRD_W +: CRD_W];
            r_wz   <= i_data[3*ROW_W + 2*CRD_W +: CRD_W];
            r_cx   <= i_data[3*ROW_W + 3*CRD_W +: CRD_W];
            r_cy   <= i_data[3*ROW_W + 4*CRD_W +: CRD_W];
            r_cz   <= i_data[3*ROW_W + 5*CRD_W +: CRD_W];
        end
    end

    always_comb begin
        o_row.last  = r_phase;
        o_row.a_row = r_phase ? r_rot1 : r_rot0;
        o_row.b_row = r_rot2;
        o_row.wx    = r_wx;
        o_row.wy    = r_wy;
        o_row.wz    = r_wz;
        o_row.q     = r_phase ? r_cy : r_cx;
        o_row.cz    = r_cz;
    end

endmodule
`default_nettype wire

// ===== rtl/prjse3_front.sv =====
`default_nettype none
module prjse3_front
    import prjse3_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
    parameter int ROT_FRAC_BITS   = ROT_FRAC_DEF,
    localparam int NS  = f_ns(COORD_FRAC_BITS, ROT_FRAC_BITS),
    localparam int DS  = f_ds(COORD_FRAC_BITS, ROT_FRAC_BITS),
    localparam int DW  = f_dw(COORD_FRAC_BITS, ROT_FRAC_BITS),
    localparam int NW  = f_nw(COORD_FRAC_BITS, ROT_FRAC_BITS),
    localparam int DDW = f_ddw(COORD_FRAC_BITS, ROT_FRAC_BITS),
    localparam int CW  = f_cw(COORD_FRAC_BITS, ROT_FRAC_BITS)
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_ce,
    input  wire logic             i_valid,
    input  wire t_row             i_row,
    input  wire logic [MD_W-1:0]  i_min_depth,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [NW-1:0]         o_n [NLANE],
    output logic [DDW-1:0]        o_d,
    output logic [NLANE-1:0]      o_neg,
    output logic [NLANE-1:0]      o_ovf
);

    logic        r_v    [FST];
    logic        r_last [FST];
    logic        r_bad  [FST-1];

    t_row                    r_f1_row;
    logic signed [PRD_W-1:0] r_f2_pa [NLANE];
    logic signed [PRD_W-1:0] r_f2_pb [NLANE];
    logic signed [ENT_W-1:0] r_f2_ae [NENT];
    logic signed [ENT_W-1:0] r_f2_be [NENT];
    logic        [CRD_W-1:0] r_f2_q;
    logic        [CRD_W-1:0] r_f2_cz;
    logic        [SQ_W-1:0]  r_f2_sq;
    logic signed [AW-1:0]    r_f3_a [NLANE];
    logic signed [AW-1:0]    r_f3_b [NLANE];
    logic        [CRD_W-1:0] r_f3_q;
    logic        [CRD_W-1:0] r_f3_cz;
    logic        [SQ_W-1:0]  r_f3_sq;
    logic signed [PP_W-1:0]  r_f4_alz [NLANE];
    logic signed [PP_W-1:0]  r_f4_ahz [NLANE];
    logic signed [PP_W-1:0]  r_f4_blq [NLANE];
    logic signed [PP_W-1:0]  r_f4_bhq [NLANE];
    logic        [SQ_W-1:0]  r_f4_sq;
    logic signed [MUL_W-1:0] r_f5_ac [NLANE];
    logic signed [MUL_W-1:0] r_f5_qb [NLANE];
    logic        [SQ_W-1:0]  r_f5_sq;
    logic signed [NUM_W-1:0] r_f6_num [NLANE];
    logic        [SQ_W-1:0]  r_f6_sq;
    logic        [NUM_W-1:0] r_f7_m [NLANE];
    logic        [NLANE-1:0] r_f7_neg;
    logic        [DW-1:0]    r_f7_den;
    logic        [NW-1:0]    r_f8_n [NLANE];
    logic        [DDW-1:0]   r_f8_d;
    logic        [NLANE-1:0] r_f8_neg;
    logic        [NLANE-1:0] r_f8_ovf;

    logic signed [CRD_W-1:0] w_cz;
    logic        [CRD_W-1:0] w_czmag;
    logic                    w_bad;

    assign w_cz    = $signed(r_f1_row.cz);
    assign w_czmag = w_cz[CRD_W-1] ? CRD_W'(-w_cz) : CRD_W'(w_cz);
    assign w_bad   = (w_cz == '0) || (w_czmag < CRD_W'(i_min_depth));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FST; k++) r_v[k] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < FST; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_last[0] <= i_row.last;
            for (int k = 1; k < FST; k++) r_last[k] <= r_last[k-1];
            r_bad[0] <= w_bad;
            for (int k = 1; k < FST-1; k++) r_bad[k] <= r_bad[k-1];
        end
    end

    // stage 1-2: row register, cross products, depth square
    always_ff @(posedge i_clk) begin
        logic signed [ENT_W-1:0] a [NENT];
        logic signed [ENT_W-1:0] b [NENT];
        logic signed [CRD_W-1:0] x, y, z;
        if (i_ce) begin
            r_f1_row <= i_row;
            for (int j = 0; j < NENT; j++) begin
                a[j] = $signed(r_f1_row.a_row[ENT_W*j +: ENT_W]);
                b[j] = $signed(r_f1_row.b_row[ENT_W*j +: ENT_W]);
                r_f2_ae[j] <= a[j];
                r_f2_be[j] <= b[j];
            end
            x = $signed(r_f1_row.wx);
            y = $signed(r_f1_row.wy);
            z = $signed(r_f1_row.wz);
            r_f2_pa[0] <= y * a[2];
            r_f2_pa[1] <= z * a[1];
            r_f2_pa[2] <= z * a[0];
            r_f2_pa[3] <= x * a[2];
            r_f2_pa[4] <= x * a[1];
            r_f2_pa[5] <= y * a[0];
            r_f2_pb[0] <= y * b[2];
            r_f2_pb[1] <= z * b[1];
            r_f2_pb[2] <= z * b[0];
            r_f2_pb[3] <= x * b[2];
            r_f2_pb[4] <= x * b[1];
            r_f2_pb[5] <= y * b[0];
            r_f2_q  <= r_f1_row.q;
            r_f2_cz <= r_f1_row.cz;
            r_f2_sq <= SQ_W'(w_czmag) * SQ_W'(w_czmag);
        end
    end

    // stage 3: Jacobian numerator rows
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int j = 0; j < NPNT; j++) begin
                r_f3_a[j] <= AW'(r_f2_ae[j]) <<< COORD_FRAC_BITS;
                r_f3_b[j] <= AW'(r_f2_be[j]) <<< COORD_FRAC_BITS;
                r_f3_a[NPNT+j] <= AW'(r_f2_pa[2*j]) - AW'(r_f2_pa[2*j+1]);
                r_f3_b[NPNT+j] <= AW'(r_f2_pb[2*j]) - AW'(r_f2_pb[2*j+1]);
            end
            r_f3_q  <= r_f2_q;
            r_f3_cz <= r_f2_cz;
            r_f3_sq <= r_f2_sq;
        end
    end

    // stage 4: partial products
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int l = 0; l < NLANE; l++) begin
                r_f4_alz[l] <= $signed({1'b0, r_f3_a[l][LO_W-1:0]}) * $signed(r_f3_cz);
                r_f4_ahz[l] <= $signed(r_f3_a[l][AW-1:LO_W]) * $signed(r_f3_cz);
                r_f4_blq[l] <= $signed({1'b0, r_f3_b[l][LO_W-1:0]}) * $signed(r_f3_q);
                r_f4_bhq[l] <= $signed(r_f3_b[l][AW-1:LO_W]) * $signed(r_f3_q);
            end
            r_f4_sq <= r_f3_sq;
        end
    end

    // stage 5-7: combine, difference, magnitude
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int l = 0; l < NLANE; l++) begin
                r_f5_ac[l] <= (MUL_W'(r_f4_ahz[l]) <<< LO_W) + MUL_W'(r_f4_alz[l]);
                r_f5_qb[l] <= (MUL_W'(r_f4_bhq[l]) <<< LO_W) + MUL_W'(r_f4_blq[l]);
                r_f6_num[l] <= NUM_W'(r_f5_ac[l]) - NUM_W'(r_f5_qb[l]);
                r_f7_neg[l] <= r_f6_num[l][NUM_W-1];
                r_f7_m[l]   <= r_f6_num[l][NUM_W-1] ? NUM_W'(-r_f6_num[l])
                                                    : NUM_W'(r_f6_num[l]);
            end
            r_f5_sq  <= r_f4_sq;
            r_f6_sq  <= r_f5_sq;
            r_f7_den <= DW'(r_f6_sq) << DS;
        end
    end

    // stage 8: rounded dividend, divisor, overflow check
    always_ff @(posedge i_clk) begin
        logic [NW-1:0] n;
        if (i_ce) begin
            for (int l = 0; l < NLANE; l++) begin
                n = (NW'(r_f7_m[l]) << (NS + 1)) + NW'(r_f7_den);
                r_f8_n[l]   <= n;
                r_f8_ovf[l] <= CW'(n) >= (CW'(r_f7_den) << (QW + 1));
            end
            r_f8_neg <= r_f7_neg;
            r_f8_d   <= DDW'(r_f7_den) << 1;
        end
    end

    assign o_valid     = r_v[FST-1];
    assign o_side.last = r_last[FST-1];
    assign o_side.bad  = r_bad[FST-2];
    assign o_n         = r_f8_n;
    assign o_d         = r_f8_d;
    assign o_neg       = r_f8_neg;
    assign o_ovf       = r_f8_ovf;

endmodule
`default_nettype wire

// ===== rtl/prjse3_div.sv =====
`default_nettype none
module prjse3_div
    import prjse3_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
    parameter int ROT_FRAC_BITS   = ROT_FRAC_DEF,
    localparam int NW  = f_nw(COORD_FRAC_BITS, ROT_FRAC_BITS),
    localparam int DDW = f_ddw(COORD_FRAC_BITS, ROT_FRAC_BITS),
    localparam int CW  = f_cw(COORD_FRAC_BITS, ROT_FRAC_BITS)
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_ce,
    input  wire logic             i_valid,
    input  wire t_side            i_side,
    input  wire logic [NW-1:0]    i_n [NLANE],
    input  wire logic [DDW-1:0]   i_d,
    input  wire logic [NLANE-1:0] i_neg,
    input  wire logic [NLANE-1:0] i_ovf,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [QW-1:0]         o_q [NLANE],
    output logic [NLANE-1:0]      o_neg,
    output logic [NLANE-1:0]      o_ovf
);

    logic             r_v    [QW];
    t_side            r_side [QW];
    logic [CW-1:0]    r_r    [QW][NLANE];
    logic [QW-1:0]    r_q    [QW][NLANE];
    logic [DDW-1:0]   r_d    [QW];
    logic [NLANE-1:0] r_neg  [QW];
    logic [NLANE-1:0] r_ovf  [QW];

    // one quotient bit per stage, restoring
    for (genvar gs = 0; gs < QW; gs++) begin : g_st
        logic             w_vin;
        t_side            w_sin;
        logic [CW-1:0]    w_rin [NLANE];
        logic [QW-1:0]    w_qin [NLANE];
        logic [DDW-1:0]   w_din;
        logic [NLANE-1:0] w_nin;
        logic [NLANE-1:0] w_oin;
        logic [CW-1:0]    w_sh;

        if (gs == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < NLANE; l++) begin
                    w_rin[l] = CW'(i_n[l]);
                    w_qin[l] = '0;
                end
            end
            assign w_vin = i_valid;
            assign w_sin = i_side;
            assign w_din = i_d;
            assign w_nin = i_neg;
            assign w_oin = i_ovf;
        end else begin : g_next
            assign w_vin = r_v[gs-1];
            assign w_sin = r_side[gs-1];
            assign w_rin = r_r[gs-1];
            assign w_qin = r_q[gs-1];
            assign w_din = r_d[gs-1];
            assign w_nin = r_neg[gs-1];
            assign w_oin = r_ovf[gs-1];
        end

        assign w_sh = CW'(w_din) << (QW - 1 - gs);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[gs] <= 1'b0;
            else if (i_ce) r_v[gs] <= w_vin;
        end

        always_ff @(posedge i_clk) begin
            logic [CW:0] t;
            if (i_ce) begin
                for (int l = 0; l < NLANE; l++) begin
                    t = {1'b0, w_rin[l]} - {1'b0, w_sh};
                    r_r[gs][l] <= t[CW] ? w_rin[l] : t[CW-1:0];
                    r_q[gs][l] <= {w_qin[l][QW-2:0], !t[CW]};
                end
                r_side[gs] <= w_sin;
                r_d[gs]    <= w_din;
                r_neg[gs]  <= w_nin;
                r_ovf[gs]  <= w_oin;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_neg   = r_neg[QW-1];
    assign o_ovf   = r_ovf[QW-1];

endmodule
`default_nettype wire

// ===== rtl/projection_jacobian_rows_se3_point.sv =====
// Projection Jacobian rows for one SE(3) point, fixed point.
// Input stream: one item per point: three rotation rows (Q2.18 entries),
// the world point and its camera-frame image (Q16.16).
// Output stream: two items per point, the u row then the v row (tlast set).
// Each row holds the point terms, the translation terms (equal to them) and
// the rotation terms, rounded to nearest and saturated to 32 bits.
// tuser flags a rejected depth (|cam_z| below min_depth or zero); its terms
// are zero.
// Configuration: one write channel for min_depth, always ready; write only
// while the pipeline is empty.
// Throughput: one row per cycle while the receiver does not stall, set by the
// row splitter feeding the pipeline one row at a time.
// Pipeline: 8 product stages, 32 one-bit divider stages, output register;
// the v row follows its u row.
// Reset empties the pipeline and sets min_depth to 1.
// When the receiver stalls the whole pipeline holds; nothing is lost.
`default_nettype none
module projection_jacobian_rows_se3_point
    import prjse3_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
    parameter int ROT_FRAC_BITS   = ROT_FRAC_DEF
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // rot_row0, rot_row1, rot_row2, world_x, world_y, world_z, cam_x, cam_y, cam_z
    input  wire logic [IN_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // jpt_x, jpt_y, jpt_z, jpose_t0, jpose_t1, jpose_t2, jpose_r0, jpose_r1, jpose_r2
    output logic [OUT_W-1:0]      o_m_tdata,
    output logic                  o_m_tlast,
    // depth_error
    output logic                  o_m_tuser,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [MD_W-1:0]  i_cfg_data
);

    localparam int NW  = f_nw(COORD_FRAC_BITS, ROT_FRAC_BITS);
    localparam int DDW = f_ddw(COORD_FRAC_BITS, ROT_FRAC_BITS);

    logic [MD_W-1:0]  r_min_depth;
    logic             r_m_valid;
    logic [OUT_W-1:0] r_m_data;
    logic             r_m_last;
    logic             r_m_user;
    logic [OUT_W-1:0] n_m_data;

    logic             w_ce;
    logic             w_row_valid;
    t_row             w_row;
    logic             w_fr_valid;
    t_side            w_fr_side;
    logic [NW-1:0]    w_fr_n [NLANE];
    logic [DDW-1:0]   w_fr_d;
    logic [NLANE-1:0] w_fr_neg;
    logic [NLANE-1:0] w_fr_ovf;
    logic             w_dv_valid;
    t_side            w_dv_side;
    logic [QW-1:0]    w_dv_q [NLANE];
    logic [NLANE-1:0] w_dv_neg;
    logic [NLANE-1:0] w_dv_ovf;

    assign w_ce        = !r_m_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min_depth <= MIN_DEPTH_RST;
        else if (i_cfg_valid) r_min_depth <= i_cfg_data;
    end

    prjse3_row_gen u_row_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_ready (o_s_tready),
        .o_valid (w_row_valid),
        .o_row   (w_row)
    );

    prjse3_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .ROT_FRAC_BITS   (ROT_FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ce        (w_ce),
        .i_valid     (w_row_valid),
        .i_row       (w_row),
        .i_min_depth (r_min_depth),
        .o_valid     (w_fr_valid),
        .o_side      (w_fr_side),
        .o_n         (w_fr_n),
        .o_d         (w_fr_d),
        .o_neg       (w_fr_neg),
        .o_ovf       (w_fr_ovf)
    );

    prjse3_div #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .ROT_FRAC_BITS   (ROT_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_fr_valid),
        .i_side  (w_fr_side),
        .i_n     (w_fr_n),
        .i_d     (w_fr_d),
        .i_neg   (w_fr_neg),
        .i_ovf   (w_fr_ovf),
        .o_valid (w_dv_valid),
        .o_side  (w_dv_side),
        .o_q     (w_dv_q),
        .o_neg   (w_dv_neg),
        .o_ovf   (w_dv_ovf)
    );

    // saturate, sign, zero on bad depth
    always_comb begin
        logic [QW-1:0] lim;
        logic [QW-1:0] mag;
        logic [QW-1:0] val;
        n_m_data = '0;
        for (int l = 0; l < NLANE; l++) begin
            lim = w_dv_neg[l] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
            mag = (w_dv_ovf[l] || (w_dv_q[l] > lim)) ? lim : w_dv_q[l];
            val = w_dv_neg[l] ? QW'(-mag) : mag;
            if (w_dv_side.bad) val = '0;
            if (l < NPNT) begin
                n_m_data[QW*l +: QW]          = val;
                n_m_data[QW*(l+NPNT) +: QW]   = val;
            end else begin
                n_m_data[QW*(l+NPNT) +: QW]   = val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_valid <= 1'b0;
        else if (w_ce) r_m_valid <= w_dv_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m_data <= n_m_data;
            r_m_last <= w_dv_side.last;
            r_m_user <= w_dv_side.bad;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_user;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("rejected depth row carries nonzero terms");

    a_trans_eq_pnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[QW*NPNT-1:0] == o_m_tdata[2*QW*NPNT-1:QW*NPNT])
        else $error("translation terms differ from point terms");

    a_two_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("item accepted before its u row was issued");

endmodule
`default_nettype wire
